// ===== hw/rtl/dsr_pkg.sv =====
// Shared types, constants and identification text for the diagnostic service responder.
// No dependencies; every other file in the block imports this package.
`timescale 1ns / 1ps

package dsr_pkg;

    localparam int TABLE_DEPTH   = 16;
    localparam int ID_STRING_MAX = 24;

    localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int RLEN_MAX = (3 + 4 * TABLE_DEPTH > 3 + ID_STRING_MAX) ?
                              3 + 4 * TABLE_DEPTH : 3 + ID_STRING_MAX;
    localparam int RLEN_W = $clog2(RLEN_MAX + 1);

    // Service identifiers.
    localparam logic [7:0] SID_SESSION  = 8'h10;
    localparam logic [7:0] SID_RESET    = 8'h11;
    localparam logic [7:0] SID_CLEAR    = 8'h14;
    localparam logic [7:0] SID_READ_DTC = 8'h19;
    localparam logic [7:0] SID_READ_DID = 8'h22;
    localparam logic [7:0] SID_WRITE_DID = 8'h2E;
    localparam logic [7:0] SID_POS_OFFSET = 8'h40;
    localparam logic [7:0] SID_NEGATIVE = 8'h7F;

    // Negative response codes.
    localparam logic [7:0] NRC_NOT_SUPPORTED = 8'h11;
    localparam logic [7:0] NRC_SUBFUNC       = 8'h12;
    localparam logic [7:0] NRC_LENGTH        = 8'h13;
    localparam logic [7:0] NRC_CONDITIONS    = 8'h22;
    localparam logic [7:0] NRC_RANGE         = 8'h31;

    // Data identifiers.
    localparam logic [15:0] DID_SW      = 16'hF190;
    localparam logic [15:0] DID_SERIAL  = 16'hF191;
    localparam logic [15:0] DID_HW      = 16'hF192;
    localparam logic [15:0] DID_VERSION = 16'hF193;
    localparam logic [15:0] DID_SESSION = 16'hF194;
    localparam logic [15:0] DID_VOLTAGE = 16'hF195;
    localparam logic [15:0] VOLTAGE_VAL = 16'd12000;

    localparam logic [7:0] DTC_STATUS_SET = 8'h0D;

    localparam logic [1:0] OUT_POSITIVE   = 2'd0;
    localparam logic [1:0] OUT_NEGATIVE   = 2'd1;
    localparam logic [1:0] OUT_RECORDED   = 2'd2;
    localparam logic [1:0] OUT_TABLE_FULL = 2'd3;

    localparam int SW_LEN     = 14;
    localparam int SERIAL_LEN = 18;
    localparam int HW_LEN     = 5;
    localparam logic [8*SW_LEN-1:0]     SW_TEXT     = "ECU-APP v2.1.0";
    localparam logic [8*SERIAL_LEN-1:0] SERIAL_TEXT = "SN-0000-2025-00042";
    localparam logic [8*HW_LEN-1:0]     HW_TEXT     = "REV-B";
    localparam int SW_CUT     = (SW_LEN > ID_STRING_MAX) ? ID_STRING_MAX : SW_LEN;
    localparam int SERIAL_CUT = (SERIAL_LEN > ID_STRING_MAX) ? ID_STRING_MAX : SERIAL_LEN;
    localparam int HW_CUT     = (HW_LEN > ID_STRING_MAX) ? ID_STRING_MAX : HW_LEN;

    typedef enum logic [2:0] {
        SRC_HDR,
        SRC_TXT_SW,
        SRC_TXT_SERIAL,
        SRC_TXT_HW,
        SRC_FAULTS
    } dsr_src_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SEARCH,
        ST_FILL,
        ST_OUT
    } dsr_state_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic srch_start;
        logic srch_step;
        logic commit;
        logic fill;
        logic beat_clr;
    } dsr_cmd_t;

    typedef struct packed {
        logic is_fault;
        logic srch_hit;
        logic srch_end;
        logic fill_done;
        logic last;
    } dsr_stat_t;

    function automatic logic [7:0] text_byte(dsr_src_t s, logic [RLEN_W-1:0] i);
        logic [7:0] b;
        b = 8'h00;
        case (s)
            SRC_TXT_SW:
                if (int'(i) < SW_LEN) b = SW_TEXT[8*(SW_LEN-1-int'(i)) +: 8];
            SRC_TXT_SERIAL:
                if (int'(i) < SERIAL_LEN) b = SERIAL_TEXT[8*(SERIAL_LEN-1-int'(i)) +: 8];
            SRC_TXT_HW:
                if (int'(i) < HW_LEN) b = HW_TEXT[8*(HW_LEN-1-int'(i)) +: 8];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/dsr_ctrl.sv =====
// Controller state machine of the diagnostic service responder.
// Depends on dsr_pkg for the state, command and status types.
`timescale 1ns / 1ps

module dsr_ctrl
    import dsr_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  dsr_stat_t stat,
    output dsr_cmd_t  cmd
);

    dsr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (stat.is_fault) begin
                    cmd.srch_start = 1'b1;
                    state_next     = ST_SEARCH;
                end else begin
                    cmd.decode = 1'b1;
                    state_next = ST_FILL;
                end
            end
            ST_SEARCH: begin
                if (stat.srch_hit || stat.srch_end) begin
                    cmd.commit = 1'b1;
                    state_next = ST_FILL;
                end else begin
                    cmd.srch_step = 1'b1;
                end
            end
            ST_FILL: begin
                if (stat.fill_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.fill = 1'b1;
                end
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (stat.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.beat_clr = 1'b1;
                        state_next   = ST_FILL;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== hw/rtl/dsr_datapath.sv =====
// Datapath of the diagnostic service responder: request capture, session and fault
// table, response decode and beat assembly. Depends on dsr_pkg.
`timescale 1ns / 1ps

module dsr_datapath
    import dsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  dsr_cmd_t    cmd,
    output dsr_stat_t   stat,
    input  logic        s_cmd,
    input  logic [7:0]  s_service_id,
    input  logic [2:0]  s_data_len,
    input  logic [7:0]  s_byte0,
    input  logic [7:0]  s_byte1,
    input  logic [7:0]  s_byte2,
    input  logic [23:0] s_fault_code,
    output logic [7:0]  m_resp_sid,
    output logic [31:0] m_payload,
    output logic [2:0]  m_byte_count,
    output logic        m_last,
    output logic [1:0]  m_outcome
);

    // Captured request.
    logic        cmd_reg;
    logic [7:0]  sid_reg;
    logic [2:0]  dlen_reg;
    logic [7:0]  b0_reg, b1_reg, b2_reg;
    logic [23:0] code_reg;

    logic [7:0]       session_reg;
    logic [CNT_W-1:0] count_reg;
    logic [23:0]      codes_reg  [TABLE_DEPTH];
    logic [7:0]       status_reg [TABLE_DEPTH];
    logic [CNT_W-1:0] idx_reg;

    // Response description and beat under assembly.
    logic [7:0]        hdr_reg [4];
    logic [RLEN_W-1:0] rlen_reg, pos_reg;
    dsr_src_t          src_reg;
    logic [7:0]        rsid_reg;
    logic [1:0]        outcome_reg;
    logic [31:0]       beat_reg;
    logic [2:0]        cnt_reg;

    // Decode results.
    logic [7:0]        dec_hdr [4];
    logic [RLEN_W-1:0] dec_rlen;
    dsr_src_t          dec_src;
    logic [7:0]        dec_rsid;
    logic [1:0]        dec_outcome;
    logic              dec_set_session;
    logic [7:0]        dec_session;
    logic              dec_clear;
    logic [15:0]       did;

    always_comb begin
        did             = {b0_reg, b1_reg};
        dec_hdr[0]      = sid_reg;
        dec_hdr[1]      = NRC_NOT_SUPPORTED;
        dec_hdr[2]      = 8'h00;
        dec_hdr[3]      = 8'h00;
        dec_rlen        = RLEN_W'(2);
        dec_src         = SRC_HDR;
        dec_rsid        = SID_NEGATIVE;
        dec_outcome     = OUT_NEGATIVE;
        dec_set_session = 1'b0;
        dec_session     = b0_reg;
        dec_clear       = 1'b0;
        case (sid_reg)
            SID_SESSION: begin
                if (dlen_reg == 3'd0) begin
                    dec_hdr[1] = NRC_LENGTH;
                end else if (!(b0_reg inside {[8'd1:8'd4]})) begin
                    dec_hdr[1] = NRC_SUBFUNC;
                end else begin
                    dec_set_session = 1'b1;
                    dec_hdr[0]      = b0_reg;
                    dec_hdr[1]      = 8'h00;
                    dec_outcome     = OUT_POSITIVE;
                end
            end
            SID_RESET: begin
                if (dlen_reg == 3'd0) begin
                    dec_hdr[1] = NRC_LENGTH;
                end else if (!(b0_reg inside {[8'd1:8'd3]})) begin
                    dec_hdr[1] = NRC_SUBFUNC;
                end else begin
                    dec_hdr[0]  = b0_reg;
                    dec_rlen    = RLEN_W'(1);
                    dec_outcome = OUT_POSITIVE;
                end
            end
            SID_READ_DID: begin
                if (dlen_reg < 3'd2) begin
                    dec_hdr[1] = NRC_LENGTH;
                end else begin
                    dec_hdr[1] = NRC_RANGE;
                    case (did)
                        DID_SW: begin
                            dec_src  = SRC_TXT_SW;
                            dec_hdr[2] = 8'(SW_CUT);
                            dec_rlen = RLEN_W'(3 + SW_CUT);
                        end
                        DID_SERIAL: begin
                            dec_src  = SRC_TXT_SERIAL;
                            dec_hdr[2] = 8'(SERIAL_CUT);
                            dec_rlen = RLEN_W'(3 + SERIAL_CUT);
                        end
                        DID_HW: begin
                            dec_src  = SRC_TXT_HW;
                            dec_hdr[2] = 8'(HW_CUT);
                            dec_rlen = RLEN_W'(3 + HW_CUT);
                        end
                        DID_VERSION: begin
                            dec_hdr[2] = 8'h01;
                            dec_hdr[3] = 8'h03;
                            dec_rlen   = RLEN_W'(4);
                        end
                        DID_SESSION: begin
                            dec_hdr[2] = session_reg;
                            dec_rlen   = RLEN_W'(3);
                        end
                        DID_VOLTAGE: begin
                            dec_hdr[2] = VOLTAGE_VAL[15:8];
                            dec_hdr[3] = VOLTAGE_VAL[7:0];
                            dec_rlen   = RLEN_W'(4);
                        end
                        default: dec_hdr[1] = NRC_RANGE;
                    endcase
                    if (dec_hdr[1] != NRC_RANGE || did inside {DID_SW, DID_SERIAL,
                            DID_HW, DID_VERSION, DID_SESSION, DID_VOLTAGE}) begin
                        dec_hdr[0]  = b0_reg;
                        dec_hdr[1]  = b1_reg;
                        dec_outcome = OUT_POSITIVE;
                    end else begin
                        dec_rlen = RLEN_W'(2);
                    end
                end
            end
            SID_WRITE_DID: begin
                if (dlen_reg < 3'd2) begin
                    dec_hdr[1] = NRC_LENGTH;
                end else if (session_reg < 8'd3) begin
                    dec_hdr[1] = NRC_CONDITIONS;
                end else if (did != DID_SESSION) begin
                    dec_hdr[1] = NRC_RANGE;
                end else begin
                    dec_set_session = (dlen_reg >= 3'd3);
                    dec_session     = b2_reg;
                    dec_hdr[0]      = b0_reg;
                    dec_hdr[1]      = b1_reg;
                    dec_outcome     = OUT_POSITIVE;
                end
            end
            SID_CLEAR: begin
                dec_clear   = 1'b1;
                dec_rlen    = '0;
                dec_outcome = OUT_POSITIVE;
            end
            SID_READ_DTC: begin
                if (dlen_reg == 3'd0) begin
                    dec_hdr[1] = NRC_LENGTH;
                end else begin
                    dec_hdr[0]  = b0_reg;
                    dec_hdr[1]  = 8'(count_reg);
                    dec_rlen    = RLEN_W'(3) + RLEN_W'({count_reg, 2'b00});
                    dec_src     = SRC_FAULTS;
                    dec_outcome = OUT_POSITIVE;
                end
            end
            default: dec_hdr[1] = NRC_NOT_SUPPORTED;
        endcase
        if (dec_outcome == OUT_POSITIVE) begin
            dec_rsid = sid_reg + SID_POS_OFFSET;
        end
    end

    // Single read port of the fault table, shared by the search and the fault listing.
    logic [RLEN_W-1:0] rel_pos;
    logic [RLEN_W-1:0] rd_sel;
    logic [23:0]       rd_code;
    logic [7:0]        rd_status;

    assign rel_pos = pos_reg - RLEN_W'(3);

    always_comb begin
        rd_sel = cmd.fill ? (rel_pos >> 2) : RLEN_W'(idx_reg);
        if (int'(rd_sel) < TABLE_DEPTH) begin
            rd_code   = codes_reg[rd_sel[IDX_W-1:0]];
            rd_status = status_reg[rd_sel[IDX_W-1:0]];
        end else begin
            rd_code   = '0;
            rd_status = '0;
        end
    end

    logic srch_end;
    assign srch_end = (idx_reg >= count_reg) || (int'(idx_reg) >= TABLE_DEPTH);

    // Next response byte.
    logic [7:0] next_byte;

    always_comb begin
        next_byte = hdr_reg[pos_reg[1:0]];
        if (pos_reg >= RLEN_W'(3)) begin
            case (src_reg)
                SRC_TXT_SW, SRC_TXT_SERIAL, SRC_TXT_HW:
                    next_byte = text_byte(src_reg, rel_pos);
                SRC_FAULTS: begin
                    case (rel_pos[1:0])
                        2'd0:    next_byte = rd_code[23:16];
                        2'd1:    next_byte = rd_code[15:8];
                        2'd2:    next_byte = rd_code[7:0];
                        default: next_byte = rd_status;
                    endcase
                end
                default: next_byte = hdr_reg[pos_reg[1:0]];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg  <= s_cmd;
            sid_reg  <= s_service_id;
            dlen_reg <= s_data_len;
            b0_reg   <= s_byte0;
            b1_reg   <= s_byte1;
            b2_reg   <= s_byte2;
            code_reg <= s_fault_code;
        end
        if (cmd.decode) begin
            for (int i = 0; i < 4; i++) hdr_reg[i] <= dec_hdr[i];
            rlen_reg    <= dec_rlen;
            src_reg     <= dec_src;
            rsid_reg    <= dec_rsid;
            outcome_reg <= dec_outcome;
        end
        if (cmd.commit) begin
            for (int i = 0; i < 4; i++) hdr_reg[i] <= 8'h00;
            rlen_reg    <= '0;
            src_reg     <= SRC_HDR;
            rsid_reg    <= 8'h00;
            outcome_reg <= (!stat.srch_hit && int'(count_reg) >= TABLE_DEPTH) ?
                           OUT_TABLE_FULL : OUT_RECORDED;
            if (stat.srch_hit) begin
                status_reg[idx_reg[IDX_W-1:0]] <= rd_status | DTC_STATUS_SET;
            end else if (int'(count_reg) < TABLE_DEPTH) begin
                codes_reg[idx_reg[IDX_W-1:0]]  <= code_reg;
                status_reg[idx_reg[IDX_W-1:0]] <= DTC_STATUS_SET;
            end
        end
        if (cmd.srch_start) begin
            idx_reg <= '0;
        end else if (cmd.srch_step) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (cmd.decode || cmd.commit) begin
            pos_reg  <= '0;
            cnt_reg  <= '0;
            beat_reg <= '0;
        end else if (cmd.beat_clr) begin
            cnt_reg  <= '0;
            beat_reg <= '0;
        end else if (cmd.fill) begin
            case (cnt_reg[1:0])
                2'd0:    beat_reg[31:24] <= next_byte;
                2'd1:    beat_reg[23:16] <= next_byte;
                2'd2:    beat_reg[15:8]  <= next_byte;
                default: beat_reg[7:0]   <= next_byte;
            endcase
            cnt_reg <= cnt_reg + 3'd1;
            pos_reg <= pos_reg + RLEN_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            session_reg <= 8'd1;
            count_reg   <= '0;
        end else begin
            if (cmd.decode && dec_set_session) session_reg <= dec_session;
            if (cmd.decode && dec_clear) begin
                count_reg <= '0;
            end else if (cmd.commit && !stat.srch_hit && int'(count_reg) < TABLE_DEPTH) begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    assign stat.is_fault  = cmd_reg;
    assign stat.srch_end  = srch_end;
    assign stat.srch_hit  = !srch_end && (rd_code == code_reg);
    assign stat.fill_done = (cnt_reg == 3'd4) || (pos_reg == rlen_reg);
    assign stat.last      = (pos_reg == rlen_reg);

    assign m_resp_sid   = rsid_reg;
    assign m_payload    = beat_reg;
    assign m_byte_count = cnt_reg;
    assign m_last       = (pos_reg == rlen_reg);
    assign m_outcome    = outcome_reg;

endmodule

// ===== hw/rtl/diagnostic_service_responder_top.sv =====
// Sequence: a request is decoded and then its response is assembled byte by byte into beats,
// each beat offered in turn before the next is filled; a fault report searches the table
// entry by entry, passing over up to 16 entries, then offers its single beat.
// Throughput: one transaction at a time; the next is taken once the last beat has gone,
// set by the byte-serial beat assembly and the one-entry-per-cycle table search.
// Reset: synchronous active-low aresetn sets session to 1 and empties the fault table.
`timescale 1ns / 1ps

module diagnostic_service_responder_top
    import dsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_service_id,
    input  logic [2:0]  s_data_len,
    input  logic [7:0]  s_byte0,
    input  logic [7:0]  s_byte1,
    input  logic [7:0]  s_byte2,
    input  logic [23:0] s_fault_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_resp_sid,
    output logic [31:0] m_payload,
    output logic [2:0]  m_byte_count,
    output logic        m_last,
    output logic [1:0]  m_outcome
);

    dsr_cmd_t  cmd;
    dsr_stat_t stat;

    dsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dsr_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_cmd        (s_cmd),
        .s_service_id (s_service_id),
        .s_data_len   (s_data_len),
        .s_byte0      (s_byte0),
        .s_byte1      (s_byte1),
        .s_byte2      (s_byte2),
        .s_fault_code (s_fault_code),
        .m_resp_sid   (m_resp_sid),
        .m_payload    (m_payload),
        .m_byte_count (m_byte_count),
        .m_last       (m_last),
        .m_outcome    (m_outcome)
    );

    // The block never takes a new transaction while a beat is on offer.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input accepted while a result beat is pending");

    // Every beat but the final one is full.
    a_full_beats: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> m_byte_count == 3'd4)
        else $error("non-final beat is not full");

    // Fault report results are a single empty beat.
    a_fault_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_outcome == OUT_RECORDED || m_outcome == OUT_TABLE_FULL)
        |-> m_last && m_byte_count == 3'd0)
        else $error("fault report result is not a single empty beat");

    // After a non-final beat is taken, the block returns to filling before the next beat is offered.
    a_refill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !m_valid && !s_ready)
        else $error("beat sequence broken after non-final beat");

endmodule
